// File: rtl/core/wsfhe_pkg.sv
// Shared types and constants for the frame header encoder.
// No dependencies; imported by every module of the block.
package wsfhe_pkg;

    // Longest header: two fixed bytes, eight length bytes, four key bytes
    localparam int HDR_BYTES_MAX = 14;
    localparam int HDR_BITS      = HDR_BYTES_MAX * 8;
    localparam int CNT_W         = $clog2(HDR_BYTES_MAX + 1);

    // Default depth of the descriptor queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ALLOWED_RSV = 2'd0;
    localparam logic [1:0] CFG_MAX_LEN     = 2'd1;
    localparam logic [1:0] CFG_IS_SERVER   = 2'd2;

    localparam int CFG_DATA_W = 63;

    // Frame opcodes that the encoder knows
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // Length form markers in the second header byte
    localparam logic [6:0] LEN_SHORT_MAX = 7'd125;
    localparam logic [6:0] LEN_MARK_16   = 7'd126;
    localparam logic [6:0] LEN_MARK_64   = 7'd127;

    typedef enum logic [3:0] {
        ERR_NONE        = 4'd0,
        ERR_OPCODE      = 4'd1,
        ERR_RSV         = 4'd2,
        ERR_LEN63       = 4'd3,
        ERR_CTRL_FRAG   = 4'd4,
        ERR_CTRL_LARGE  = 4'd5,
        ERR_FRAME_LARGE = 4'd6,
        ERR_MASK_MISS   = 4'd7,
        ERR_MASK_EXTRA  = 4'd8
    } t_err;

    // One classified request: its bytes, first byte in the top bits
    typedef struct packed {
        t_err                err;
        logic [CNT_W-1:0]    nbytes;
        logic [HDR_BITS-1:0] bytes;
    } t_desc;

endpackage

// File: rtl/core/wsfhe_front.sv
// Front end: configuration registers, request checks and header assembly.
// Depends on wsfhe_pkg for the descriptor type, opcodes and error codes.
module wsfhe_front import wsfhe_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_final_flag,
    input  logic [7:0]            i_reserved_bits,
    input  logic [3:0]            i_opcode,
    input  logic [63:0]           i_payload_length,
    input  logic                  i_mask_present,
    input  logic [31:0]           i_mask_key,
    output t_desc                 o_desc
);

    logic [2:0]            r_allowed_rsv;
    logic [CFG_DATA_W-1:0] r_max_len;
    logic                  r_is_server;

    // Write configuration; unknown indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allowed_rsv <= '0;
            r_max_len     <= '0;
            r_is_server   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ALLOWED_RSV: r_allowed_rsv <= i_cfg_data[2:0];
                CFG_MAX_LEN:     r_max_len     <= i_cfg_data;
                CFG_IS_SERVER:   r_is_server   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic op_known;
    logic rsv_bad;
    logic ctrl_frame;
    logic ctrl_large;
    logic over_max;
    t_err err;

    // Check the request in priority order
    always_comb begin
        case (i_opcode)
            OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG: op_known = 1'b1;
            default: op_known = 1'b0;
        endcase
        rsv_bad    = (|i_reserved_bits[7:3]) || (|(i_reserved_bits[2:0] & ~r_allowed_rsv));
        ctrl_frame = i_opcode[3];
        ctrl_large = i_payload_length > {57'd0, LEN_SHORT_MAX};
        over_max   = (r_max_len != '0) && (i_payload_length[62:0] > r_max_len);
        if (!op_known)                                err = ERR_OPCODE;
        else if (rsv_bad)                             err = ERR_RSV;
        else if (i_payload_length[63])                err = ERR_LEN63;
        else if (ctrl_frame && !i_final_flag)         err = ERR_CTRL_FRAG;
        else if (ctrl_frame && ctrl_large)            err = ERR_CTRL_LARGE;
        else if (over_max)                            err = ERR_FRAME_LARGE;
        else if (!r_is_server && !i_mask_present)     err = ERR_MASK_MISS;
        else if (r_is_server && i_mask_present)       err = ERR_MASK_EXTRA;
        else                                          err = ERR_NONE;
    end

    logic [7:0]       byte0;
    logic             mflag;
    logic [CNT_W-1:0] key_bytes;

    // Assemble header bytes in wire order, key after the length field
    always_comb begin
        byte0     = {i_final_flag, i_reserved_bits[2:0], i_opcode};
        mflag     = i_mask_present;
        key_bytes = i_mask_present ? CNT_W'(4) : CNT_W'(0);
        o_desc.err = err;
        if (err != ERR_NONE) begin
            o_desc.nbytes = CNT_W'(1);
            o_desc.bytes  = '0;
        end else if (!ctrl_large) begin
            o_desc.nbytes = CNT_W'(2) + key_bytes;
            o_desc.bytes  = {byte0, mflag, i_payload_length[6:0], i_mask_key, 64'd0};
        end else if (i_payload_length[63:16] == 48'd0) begin
            o_desc.nbytes = CNT_W'(4) + key_bytes;
            o_desc.bytes  = {byte0, mflag, LEN_MARK_16, i_payload_length[15:0],
                             i_mask_key, 48'd0};
        end else begin
            o_desc.nbytes = CNT_W'(10) + key_bytes;
            o_desc.bytes  = {byte0, mflag, LEN_MARK_64, i_payload_length, i_mask_key};
        end
    end

endmodule

// File: rtl/core/wsfhe_queue.sv
// Descriptor queue that decouples the front end from the byte serializer.
// Depends on wsfhe_pkg for the descriptor type.
module wsfhe_queue import wsfhe_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF    // 2 or more
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    input  logic  i_pop,
    output t_desc o_desc,
    output logic  o_empty,
    output logic  o_full
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    t_desc          r_mem [DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_count;

    // Advance pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + PW'(1);
            if (i_pop)  r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + PW'(1);
            if (i_push && !i_pop)      r_count <= r_count + CW'(1);
            else if (!i_push && i_pop) r_count <= r_count - CW'(1);
        end
    end

    // Hold entries
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_desc;
    end

    assign o_desc  = r_mem[r_rp];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));

endmodule

// File: rtl/core/wsfhe_back.sv
// Back end: shifts one descriptor out as header words, one word per cycle.
// Depends on wsfhe_pkg for the descriptor type and error codes.
module wsfhe_back import wsfhe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_desc      i_desc,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_valid,
    output logic [7:0] o_header_byte,
    output logic       o_last_byte,
    output logic [3:0] o_error_code
);

    logic [HDR_BITS-1:0] r_shift;
    logic [CNT_W-1:0]    r_left;
    t_err                r_err;

    // Take the next descriptor while idle or as the current one sends its last word
    assign o_pop = (r_left <= CNT_W'(1)) && !i_empty;

    // Load or shift the word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_err  <= ERR_NONE;
        end else if (o_pop) begin
            r_shift <= i_desc.bytes;
            r_left  <= i_desc.nbytes;
            r_err   <= i_desc.err;
        end else if (r_left != '0) begin
            r_shift <= {r_shift[HDR_BITS-9:0], 8'h00};
            r_left  <= r_left - CNT_W'(1);
        end
    end

    assign o_valid       = (r_left != '0);
    assign o_header_byte = r_shift[HDR_BITS-1 -: 8];
    assign o_last_byte   = (r_left == CNT_W'(1));
    assign o_error_code  = r_err;

endmodule

// File: rtl/core/ws_frame_header_encoder.sv
// Frame header encoder: a taken request is queued, then serialized at one word per cycle.
// A request gives 1 word (error) or 2 to 14 header words.
// Busy rises only while the descriptor queue is full.
// The receiver cannot stall: o_valid marks each word for exactly one cycle.
// Synchronous active-low reset clears the configuration registers and the queue.
// Depends on wsfhe_pkg, wsfhe_front, wsfhe_queue and wsfhe_back.
module ws_frame_header_encoder import wsfhe_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF    // 2 or more
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_final_flag,
    input  logic [7:0]            i_reserved_bits,
    input  logic [3:0]            i_opcode,
    input  logic [63:0]           i_payload_length,
    input  logic                  i_mask_present,
    input  logic [31:0]           i_mask_key,
    output logic                  o_valid,
    output logic [7:0]            o_header_byte,
    output logic                  o_last_byte,
    output logic [3:0]            o_error_code
);

    t_desc front_desc;
    t_desc queue_desc;
    logic  q_empty;
    logic  q_full;
    logic  q_pop;
    logic  accept;

    // Take a request whenever the queue has room
    assign busy   = q_full;
    assign accept = start && !q_full;

    wsfhe_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_final_flag     (i_final_flag),
        .i_reserved_bits  (i_reserved_bits),
        .i_opcode         (i_opcode),
        .i_payload_length (i_payload_length),
        .i_mask_present   (i_mask_present),
        .i_mask_key       (i_mask_key),
        .o_desc           (front_desc)
    );

    wsfhe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_desc  (front_desc),
        .i_pop   (q_pop),
        .o_desc  (queue_desc),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    wsfhe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_desc        (queue_desc),
        .i_empty       (q_empty),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .o_header_byte (o_header_byte),
        .o_last_byte   (o_last_byte),
        .o_error_code  (o_error_code)
    );

endmodule

// File: verif/tb_ws_frame_header_encoder.sv
// Self-checking testbench for ws_frame_header_encoder: directed table, then random requests.
// Expected header words come from a local predictor kept in step with the register writes.
// Depends on wsfhe_pkg and the ws_frame_header_encoder RTL.
`timescale 1ns / 1ps

module tb_ws_frame_header_encoder;
    import wsfhe_pkg::*;

    localparam int          HALF_PERIOD   = 4;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES  = 16;
    localparam int          MAX_REPORTS   = 10;
    localparam int          RAND_PHASES   = 7;
    localparam int          ITEMS_PER_PH  = 60;
    localparam logic [1:0]  CFG_UNUSED    = 2'd3;
    localparam logic [63:0] LEN63_LIMIT   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LEN16_LIMIT   = 64'h0000_0000_0000_FFFF;

    typedef struct {
        logic        fin;
        logic [7:0]  rsv;
        logic [3:0]  op;
        logic [63:0] len;
        logic        mask;
        logic [31:0] key;
    } t_frame_req;

    typedef struct {
        logic [7:0] hdr;
        logic       last;
        t_err       err;
    } t_hdr_word;

    typedef struct {
        int unsigned phase;
        t_frame_req  req;
        t_err        err;    // ERR_NONE: take the words from the predictor
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [1:0]            i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  start;
    logic                  busy;
    logic                  i_final_flag;
    logic [7:0]            i_reserved_bits;
    logic [3:0]            i_opcode;
    logic [63:0]           i_payload_length;
    logic                  i_mask_present;
    logic [31:0]           i_mask_key;
    logic                  o_valid;
    logic [7:0]            o_header_byte;
    logic                  o_last_byte;
    logic [3:0]            o_error_code;

    // Register mirror used by the predictor
    logic [2:0]            allowed_rsv_mirror;
    logic [62:0]           max_len_mirror;
    logic                  is_server_mirror;

    t_hdr_word             expected_words[$];
    t_dir_row              directed_rows[$];

    int unsigned           fail_count;
    int unsigned           items_sent;
    int unsigned           words_checked;
    int unsigned           error_words;
    int unsigned           settings_applied;
    int unsigned           stall_cycles;

    ws_frame_header_encoder u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .start            (start),
        .busy             (busy),
        .i_final_flag     (i_final_flag),
        .i_reserved_bits  (i_reserved_bits),
        .i_opcode         (i_opcode),
        .i_payload_length (i_payload_length),
        .i_mask_present   (i_mask_present),
        .i_mask_key       (i_mask_key),
        .o_valid          (o_valid),
        .o_header_byte    (o_header_byte),
        .o_last_byte      (o_last_byte),
        .o_error_code     (o_error_code)
    );

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Run the request checks in the block's order; first failure wins
    function automatic t_err classify_request(t_frame_req r);
        logic known;
        case (r.op)
            OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG: known = 1'b1;
            default: known = 1'b0;
        endcase
        if (!known)
            return ERR_OPCODE;
        if (r.rsv[7:3] != 5'd0 || (r.rsv[2:0] & ~allowed_rsv_mirror) != 3'd0)
            return ERR_RSV;
        if (r.len > LEN63_LIMIT)
            return ERR_LEN63;
        if (r.op >= OP_CLOSE) begin
            if (!r.fin)
                return ERR_CTRL_FRAG;
            if (r.len > 64'(LEN_SHORT_MAX))
                return ERR_CTRL_LARGE;
        end
        if (max_len_mirror != 63'd0 && r.len > {1'b0, max_len_mirror})
            return ERR_FRAME_LARGE;
        if (!is_server_mirror && !r.mask)
            return ERR_MASK_MISS;
        if (is_server_mirror && r.mask)
            return ERR_MASK_EXTRA;
        return ERR_NONE;
    endfunction

    // Queue the header words that one accepted request should produce
    function automatic void predict_header_words(t_frame_req r);
        logic [7:0] seq[$];
        t_err       err;
        t_hdr_word  w;
        err = classify_request(r);
        if (err != ERR_NONE) begin
            w.hdr  = 8'h00;
            w.last = 1'b1;
            w.err  = err;
            expected_words.push_back(w);
            return;
        end
        seq.push_back({r.fin, r.rsv[2:0], r.op});
        if (r.len <= 64'(LEN_SHORT_MAX)) begin
            seq.push_back({r.mask, r.len[6:0]});
        end else if (r.len <= LEN16_LIMIT) begin
            seq.push_back({r.mask, LEN_MARK_16});
            seq.push_back(r.len[15:8]);
            seq.push_back(r.len[7:0]);
        end else begin
            seq.push_back({r.mask, LEN_MARK_64});
            for (int i = 7; i >= 0; i--)
                seq.push_back(r.len[i*8 +: 8]);
        end
        if (r.mask) begin
            for (int i = 3; i >= 0; i--)
                seq.push_back(r.key[i*8 +: 8]);
        end
        foreach (seq[i]) begin
            w.hdr  = seq[i];
            w.last = (i == seq.size() - 1);
            w.err  = ERR_NONE;
            expected_words.push_back(w);
        end
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    function automatic t_dir_row dir_row(int unsigned phase, logic fin, logic [7:0] rsv,
                                         logic [3:0] op, logic [63:0] len, logic mask,
                                         logic [31:0] key, t_err err);
        t_dir_row row;
        row.phase = phase;
        row.req   = '{fin, rsv, op, len, mask, key};
        row.err   = err;
        return row;
    endfunction

    // Build a request: mostly well-formed for the current settings, some pure noise
    function automatic t_frame_req random_request();
        t_frame_req r;
        r.key = $urandom;
        if ($urandom_range(0, 9) < 2) begin
            r.fin  = 1'($urandom);
            r.rsv  = 8'($urandom);
            r.op   = 4'($urandom);
            r.len  = {$urandom, $urandom};
            r.mask = 1'($urandom);
            return r;
        end
        case ($urandom_range(0, 5))
            0: r.op = OP_CONT;
            1: r.op = OP_TEXT;
            2: r.op = OP_BINARY;
            3: r.op = OP_CLOSE;
            4: r.op = OP_PING;
            default: r.op = OP_PONG;
        endcase
        r.fin = (r.op >= OP_CLOSE) ? 1'b1 : 1'($urandom);
        r.rsv = {5'd0, 3'($urandom) & allowed_rsv_mirror};
        case ($urandom_range(0, 3))
            0: r.len = 64'($urandom_range(0, 125));
            1: r.len = 64'($urandom_range(126, 65535));
            2: r.len = {32'd0, $urandom} | 64'h1_0000;
            default: r.len = {1'b0, 31'($urandom), $urandom};
        endcase
        if (r.op >= OP_CLOSE)
            r.len = r.len % 64'd126;
        if (max_len_mirror != 63'd0 && r.len > {1'b0, max_len_mirror})
            r.len = r.len % ({1'b0, max_len_mirror} + 64'd1);
        r.mask = !is_server_mirror;
        return r;
    endfunction

    // Present one request after an optional gap and hold it until taken
    task automatic send_request(t_frame_req r, t_err typed_err, int unsigned gap);
        t_hdr_word w;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_final_flag     <= r.fin;
        i_reserved_bits  <= r.rsv;
        i_opcode         <= r.op;
        i_payload_length <= r.len;
        i_mask_present   <= r.mask;
        i_mask_key       <= r.key;
        do @(posedge i_clk); while (busy !== 1'b0);
        items_sent++;
        if (typed_err != ERR_NONE) begin
            w.hdr  = 8'h00;
            w.last = 1'b1;
            w.err  = typed_err;
            expected_words.push_back(w);
        end else begin
            predict_header_words(r);
        end
    endtask

    // Drop start and wait for every outstanding word
    task automatic wait_drained();
        start <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_ALLOWED_RSV: allowed_rsv_mirror = data[2:0];
            CFG_MAX_LEN:     max_len_mirror     = data;
            CFG_IS_SERVER:   is_server_mirror   = data[0];
            default: ;
        endcase
    endtask

    // Write all registers, plus the unused index that must be ignored
    task automatic apply_settings(logic [2:0] rsv_mask, logic [62:0] max_len, logic server);
        logic [CFG_DATA_W-1:0] noise;
        noise = {31'($urandom), $urandom};
        write_reg(CFG_UNUSED, noise);
        write_reg(CFG_ALLOWED_RSV, {noise[62:3], rsv_mask});
        write_reg(CFG_MAX_LEN, max_len);
        write_reg(CFG_IS_SERVER, {noise[62:1], server});
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // Check every output word against the oldest expectation
    always @(posedge i_clk) begin
        t_hdr_word w;
        if (i_rst_n && o_valid) begin
            words_checked++;
            if (o_error_code != 4'(ERR_NONE))
                error_words++;
            if (expected_words.size() == 0) begin
                note_failure($sformatf("word with none expected: hdr=%02h last=%0b err=%0d",
                                       o_header_byte, o_last_byte, o_error_code));
            end else begin
                w = expected_words.pop_front();
                if (o_header_byte !== w.hdr || o_last_byte !== w.last ||
                    o_error_code !== 4'(w.err))
                    note_failure($sformatf("exp hdr=%02h last=%0b err=%0d, got hdr=%02h last=%0b err=%0d",
                                           w.hdr, w.last, w.err, o_header_byte,
                                           o_last_byte, o_error_code));
            end
        end
    end

    // Stop the run if no word moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no traffic for %0d cycles", STALL_LIMIT);
                $display("** ws_frame_header_encoder: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        t_frame_req  r;
        int unsigned cur_phase;
        int unsigned gap;
        logic [2:0]  rsv_mask;
        logic [62:0] max_len;
        logic        server;

        fail_count       = 0;
        items_sent       = 0;
        words_checked    = 0;
        error_words      = 0;
        settings_applied = 0;
        stall_cycles     = 0;
        allowed_rsv_mirror = 3'd0;
        max_len_mirror     = 63'd0;
        is_server_mirror   = 1'b0;

        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= 2'd0;
        i_cfg_data       <= '0;
        start            <= 1'b0;
        i_final_flag     <= 1'b0;
        i_reserved_bits  <= 8'd0;
        i_opcode         <= OP_CONT;
        i_payload_length <= 64'd0;
        i_mask_present   <= 1'b0;
        i_mask_key       <= 32'd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase 0 runs on reset settings: no reserved bits, no limit, client
        directed_rows.push_back(dir_row(0, 1, 8'h00, 4'h3, 64'd0, 1, 32'h1234_5678,
                                        ERR_OPCODE));
        directed_rows.push_back(dir_row(0, 1, 8'hFF, 4'hF, '1, 0, 32'h0, ERR_OPCODE));
        directed_rows.push_back(dir_row(0, 1, 8'h80, OP_TEXT, 64'd5, 1, 32'h0, ERR_RSV));
        directed_rows.push_back(dir_row(0, 1, 8'h01, OP_TEXT, 64'd5, 1, 32'h0, ERR_RSV));
        directed_rows.push_back(dir_row(0, 1, 8'h00, OP_BINARY, 64'h8000_0000_0000_0000, 1,
                                        32'h0, ERR_LEN63));
        directed_rows.push_back(dir_row(0, 0, 8'h00, OP_CLOSE, '1, 1, 32'h0, ERR_LEN63));
        directed_rows.push_back(dir_row(0, 0, 8'h00, OP_PING, 64'd200, 1, 32'h0,
                                        ERR_CTRL_FRAG));
        directed_rows.push_back(dir_row(0, 1, 8'h00, OP_PONG, 64'd126, 1, 32'h0,
                                        ERR_CTRL_LARGE));
        directed_rows.push_back(dir_row(0, 1, 8'h00, OP_TEXT, 64'd0, 0, 32'h0, ERR_MASK_MISS));
        directed_rows.push_back(dir_row(0, 1, 8'h00, OP_TEXT, 64'd0, 1, 32'hFFFF_FFFF,
                                        ERR_NONE));
        directed_rows.push_back(dir_row(0, 0, 8'h00, OP_CONT, 64'd125, 1, 32'h0, ERR_NONE));
        directed_rows.push_back(dir_row(0, 1, 8'h00, OP_BINARY, 64'd126, 1, 32'hDEAD_BEEF,
                                        ERR_NONE));
        directed_rows.push_back(dir_row(0, 1, 8'h00, OP_BINARY, 64'hFFFF, 1, 32'h0102_0304,
                                        ERR_NONE));
        directed_rows.push_back(dir_row(0, 0, 8'h00, OP_TEXT, 64'h1_0000, 1, 32'h8000_0001,
                                        ERR_NONE));
        directed_rows.push_back(dir_row(0, 1, 8'h00, OP_BINARY, LEN63_LIMIT, 1, 32'hA5A5_5A5A,
                                        ERR_NONE));
        directed_rows.push_back(dir_row(0, 1, 8'h00, OP_CLOSE, 64'd125, 1, 32'h7F7F_0000,
                                        ERR_NONE));
        directed_rows.push_back(dir_row(0, 1, 8'h00, OP_PING, 64'd0, 1, 32'h0, ERR_NONE));
        // Phase 1: all reserved bits allowed, limit of 1000 bytes, server
        directed_rows.push_back(dir_row(1, 1, 8'h07, OP_TEXT, 64'd1000, 0, 32'h0, ERR_NONE));
        directed_rows.push_back(dir_row(1, 1, 8'h08, OP_TEXT, 64'd1, 0, 32'h0, ERR_RSV));
        directed_rows.push_back(dir_row(1, 1, 8'h05, OP_BINARY, 64'd1001, 0, 32'h0,
                                        ERR_FRAME_LARGE));
        directed_rows.push_back(dir_row(1, 1, 8'h00, OP_PONG, 64'd125, 1, 32'h0,
                                        ERR_MASK_EXTRA));
        directed_rows.push_back(dir_row(1, 1, 8'h02, OP_CLOSE, 64'd126, 0, 32'h0,
                                        ERR_CTRL_LARGE));
        directed_rows.push_back(dir_row(1, 1, 8'h00, OP_PING, 64'd3, 0, 32'h0, ERR_NONE));

        // Walk the directed table, switching settings when the phase changes
        cur_phase = 0;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].phase != cur_phase) begin
                wait_drained();
                apply_settings(3'd7, 63'd1000, 1'b1);
                cur_phase = directed_rows[i].phase;
            end
            send_request(directed_rows[i].req, directed_rows[i].err, 0);
        end

        // Random phases: extremes first, then random settings; no gaps in the last
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: begin
                    rsv_mask = 3'd7;
                    max_len  = 63'd0;
                    server   = 1'b1;
                end
                1: begin
                    rsv_mask = 3'd0;
                    max_len  = LEN63_LIMIT[62:0];
                    server   = 1'b0;
                end
                2: begin
                    rsv_mask = 3'd3;
                    max_len  = 63'd125;
                    server   = 1'b1;
                end
                default: begin
                    rsv_mask = 3'($urandom);
                    server   = 1'($urandom);
                    case ($urandom_range(0, 3))
                        0: max_len = 63'd0;
                        1: max_len = 63'($urandom_range(1, 300));
                        2: max_len = 63'($urandom_range(126, 70000));
                        default: max_len = {31'($urandom), $urandom};
                    endcase
                end
            endcase
            apply_settings(rsv_mask, max_len, server);
            for (int n = 0; n < ITEMS_PER_PH; n++) begin
                r = random_request();
                gap = 0;
                if (ph != RAND_PHASES - 1 && $urandom_range(0, 3) == 0)
                    gap = $urandom_range(1, 13);
                send_request(r, ERR_NONE, gap);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d header requests under %0d register settings.",
                 items_sent, settings_applied + 1);
        $display("Checked %0d output words, %0d of them error words; %0d mismatches.",
                 words_checked, error_words, fail_count);
        if (fail_count == 0) begin
            $display("** ws_frame_header_encoder: PASSED **");
        end else begin
            $display("** ws_frame_header_encoder: FAILED **");
        end
        $finish;
    end

endmodule
